// ===== rtl/utf8pt_pkg.sv =====
// Shared types, constants and the code point classifier of the UTF-8 pretokenizer.
package utf8pt_pkg;

    localparam int CP_W = 21;

    // Lead byte patterns
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_CODE = 8'hF0;

    localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

    localparam logic [CP_W-1:0] CJK_LO   = 21'h004E00;
    localparam logic [CP_W-1:0] CJK_HI   = 21'h009FFF;
    localparam logic [CP_W-1:0] KANA_LO  = 21'h003040;
    localparam logic [CP_W-1:0] KANA_HI  = 21'h0030FF;
    localparam logic [CP_W-1:0] CJKA_LO  = 21'h003400;
    localparam logic [CP_W-1:0] CJKA_HI  = 21'h004DBF;
    localparam logic [CP_W-1:0] ASCII_HI = 21'h00007F;

    localparam logic [3:0] MAX_DIGIT_RUN_RESET = 4'd3;

    typedef enum logic [2:0] {
        CLS_DIGIT   = 3'd0,
        CLS_CJK     = 3'd1,
        CLS_NEWLINE = 3'd2,
        CLS_SPACE   = 3'd3,
        CLS_LETTER  = 3'd4,
        CLS_OTHER   = 3'd5,
        CLS_NONE    = 3'd7
    } piece_class_t;

    // One decoded code point passed from the decoder to the piece tracker
    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            last;
    } cp_item_t;

    function automatic piece_class_t class_of(input logic [CP_W-1:0] cp);
        piece_class_t k;
        if (cp >= 21'h30 && cp <= 21'h39)
            k = CLS_DIGIT;
        else if ((cp >= CJK_LO && cp <= CJK_HI) || (cp >= KANA_LO && cp <= KANA_HI) ||
                 (cp >= CJKA_LO && cp <= CJKA_HI))
            k = CLS_CJK;
        else if (cp == 21'h0D || cp == 21'h0A)
            k = CLS_NEWLINE;
        else if (cp == 21'h20 || cp == 21'h09)
            k = CLS_SPACE;
        else if ((cp >= 21'h41 && cp <= 21'h5A) || (cp >= 21'h61 && cp <= 21'h7A) ||
                 cp > ASCII_HI)
            k = CLS_LETTER;
        else
            k = CLS_OTHER;
        return k;
    endfunction

endpackage

// ===== rtl/utf8_pretokenizer_boundary_core.sv =====
// Top level of the UTF-8 decoder and pretokenizer boundary marker.
//
// Input stream: one text byte per item in s_tdata, s_tlast on the final byte
// of a text. Output stream: one decoded code point per item in m_tdata, with
// new_piece and the piece class in m_tuser and m_tlast on the final code point.
// Bytes inside a multi-byte sequence give no output item; a lead byte that is
// invalid gives U+FFFD, and a text that ends mid-sequence flushes its partial
// value. After the final code point all decode and piece state is cleared.
// The configuration channel writes max_digit_run (reset value 3); the user
// must write it only while idle, the block itself does not enforce this.
// Bytes are taken one per cycle while s_tready is high. A finished code point
// is written into the decoder queue, then moves into the output register.
// A stalled receiver holds the output register; the queue of QUEUE_DEPTH
// entries keeps taking bytes until it fills, then s_tready drops.
// Reset clears the decoder, the piece state and the queue; no item is held.
module utf8_pretokenizer_boundary_core
    import utf8pt_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,   // end_of_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [20:0] code_point, [23:21] zero
    output logic [3:0]  m_tuser,   // [0] new_piece, [3:1] piece_class
    output logic        m_tlast,   // last_of_text
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data
);

    logic            q_push;
    cp_item_t        q_push_item;
    logic            q_full;
    logic            q_pop;
    logic            q_head_valid;
    cp_item_t        q_head_item;
    logic [3:0]      max_digit_run_reg;
    logic [CP_W-1:0] out_cp;
    logic            out_new;
    logic [2:0]      out_class;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_digit_run_reg <= MAX_DIGIT_RUN_RESET;
        else if (cfg_valid && cfg_ready)
            max_digit_run_reg <= cfg_data;
    end

    utf8pt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .full      (q_full),
        .push      (q_push),
        .push_item (q_push_item)
    );

    utf8pt_queue #(
        .WIDTH ($bits(cp_item_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_push_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_data  (q_head_item)
    );

    utf8pt_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .max_digit_run   (max_digit_run_reg),
        .head_valid      (q_head_valid),
        .head_item       (q_head_item),
        .pop             (q_pop),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_code_point  (out_cp),
        .out_new_piece   (out_new),
        .out_piece_class (out_class),
        .out_last        (m_tlast)
    );

    assign m_tdata = {3'b000, out_cp};
    assign m_tuser = {out_class, out_new};

`ifndef NO_ASSERTIONS
    // The final byte of a text always yields a code point marked last
    a_last_flushes: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |-> q_push && q_push_item.last)
        else $error("final byte of text produced no last code point");

    // The decoder never pushes into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("push into full queue");

    // A digit piece only carries ASCII digits
    a_digit_class: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[3:1] == CLS_DIGIT |->
            m_tdata[20:0] >= 21'h30 && m_tdata[20:0] <= 21'h39)
        else $error("digit piece holds a non-digit code point");
`endif

endmodule

// ===== rtl/utf8pt_front.sv =====
// UTF-8 byte decoder: gathers sequences and pushes finished code points.
module utf8pt_front
    import utf8pt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  logic [7:0] in_byte,
    input  logic     in_last,
    input  logic     full,
    output logic     push,
    output cp_item_t push_item
);

    logic [1:0]      pending_reg;
    logic [1:0]      pending_next;
    logic [CP_W-1:0] partial_reg;
    logic [CP_W-1:0] partial_next;
    logic [CP_W-1:0] cont_point;
    logic [CP_W-1:0] cp;
    logic            emit;
    logic            accept;

    assign in_ready = !full;
    assign accept   = in_valid && in_ready;
    assign cont_point = {partial_reg[CP_W-7:0], in_byte[5:0]};

    always_comb
    begin
        emit         = 1'b0;
        cp           = '0;
        pending_next = 2'd0;
        partial_next = '0;
        if (pending_reg != 2'd0)
        begin
            if (pending_reg != 2'd1 && !in_last)
            begin
                pending_next = pending_reg - 2'd1;
                partial_next = cont_point;
            end
            else
            begin
                emit = 1'b1;
                cp   = cont_point;
            end
        end
        else if (!in_byte[7])
        begin
            emit = 1'b1;
            cp   = {{(CP_W-8){1'b0}}, in_byte};
        end
        else if ((in_byte & LEAD2_MASK) == LEAD2_CODE)
        begin
            partial_next = {{(CP_W-5){1'b0}}, in_byte[4:0]};
            pending_next = 2'd1;
        end
        else if ((in_byte & LEAD3_MASK) == LEAD3_CODE)
        begin
            partial_next = {{(CP_W-4){1'b0}}, in_byte[3:0]};
            pending_next = 2'd2;
        end
        else if ((in_byte & LEAD4_MASK) == LEAD4_CODE)
        begin
            partial_next = {{(CP_W-3){1'b0}}, in_byte[2:0]};
            pending_next = 2'd3;
        end
        else
        begin
            emit = 1'b1;
            cp   = REPLACEMENT_CP;
        end

        // Flush a lead byte that closes the text as its partial value
        if (pending_reg == 2'd0 && pending_next != 2'd0 && in_last)
        begin
            emit         = 1'b1;
            cp           = partial_next;
            pending_next = 2'd0;
            partial_next = '0;
        end
    end

    assign push                 = accept && emit;
    assign push_item.code_point = cp;
    assign push_item.last       = in_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
            partial_reg <= '0;
        end
        else if (accept)
        begin
            pending_reg <= pending_next;
            partial_reg <= partial_next;
        end
    end

endmodule

// ===== rtl/utf8pt_queue.sv =====
// Small register queue between the decoder and the piece tracker.
module utf8pt_queue #(
    parameter int WIDTH = 22,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

// ===== rtl/utf8pt_back.sv =====
// Piece tracker: classes each code point, marks piece starts, holds the output item.
module utf8pt_back
    import utf8pt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [3:0]  max_digit_run,
    input  logic        head_valid,
    input  cp_item_t    head_item,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [CP_W-1:0] out_code_point,
    output logic        out_new_piece,
    output logic [2:0]  out_piece_class,
    output logic        out_last
);

    piece_class_t    class_reg;
    piece_class_t    class_next;
    logic [3:0]      count_reg;
    logic [3:0]      count_next;
    piece_class_t    k;
    logic            join_piece;
    logic            valid_reg;
    logic [CP_W-1:0] cp_reg;
    logic            new_reg;
    piece_class_t    pclass_reg;
    logic            last_reg;

    assign pop = head_valid && (!valid_reg || out_ready);
    assign k   = class_of(head_item.code_point);

    always_comb
    begin
        if (k == CLS_DIGIT)
            join_piece = (class_reg == CLS_DIGIT) && (count_reg < max_digit_run);
        else if (class_reg == CLS_OTHER)
            join_piece = (k == CLS_OTHER) ||
                         (k == CLS_LETTER && head_item.code_point > ASCII_HI);
        else
            join_piece = (class_reg == k);

        class_next = join_piece ? class_reg : k;
        count_next = join_piece ? count_reg : 4'd0;
        if (k == CLS_DIGIT)
            count_next = count_next + 4'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            class_reg <= CLS_NONE;
            count_reg <= 4'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                // Close the text: the next code point opens a fresh piece
                class_reg <= head_item.last ? CLS_NONE : class_next;
                count_reg <= head_item.last ? 4'd0 : count_next;
                valid_reg <= 1'b1;
            end
            else if (out_ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cp_reg     <= head_item.code_point;
            new_reg    <= !join_piece;
            pclass_reg <= class_next;
            last_reg   <= head_item.last;
        end
    end

    assign out_valid       = valid_reg;
    assign out_code_point  = cp_reg;
    assign out_new_piece   = new_reg;
    assign out_piece_class = pclass_reg;
    assign out_last        = last_reg;

endmodule

// ===== tb/utf8_pretokenizer_boundary_checker.sv =====
// Checker for the UTF-8 pretokenizer: predicts code points and piece marks, compares results.
`timescale 1ns / 1ps

module utf8_pretokenizer_boundary_checker
    import utf8pt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] text_byte
    input  logic        s_tlast,   // end_of_text
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // [20:0] code_point, [23:21] zero
    input  logic [3:0]  m_tuser,   // [0] new_piece, [3:1] piece_class
    input  logic        m_tlast,   // last_of_text
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [3:0]  cfg_data,
    output int          fail_count,
    output int          pending_count
);

    typedef struct packed {
        logic [CP_W-1:0] point;
        logic            fresh;
        piece_class_t    cls;
        logic            last;
    } decoded_t;

    decoded_t        points_due[$];

    logic [3:0]      run_limit;
    logic [1:0]      bytes_left;
    logic [CP_W-1:0] gathered;
    piece_class_t    open_class;
    logic [3:0]      digit_run;

    function automatic piece_class_t lone_class(input logic [CP_W-1:0] cp);
        piece_class_t k;
        k = CLS_OTHER;
        if (cp > ASCII_HI)
        begin
            if ((cp >= KANA_LO && cp <= KANA_HI) || (cp >= CJKA_LO && cp <= CJKA_HI) ||
                (cp >= CJK_LO && cp <= CJK_HI))
                k = CLS_CJK;
            else
                k = CLS_LETTER;
        end
        else
        begin
            case (cp[6:0])
                7'h0A, 7'h0D: k = CLS_NEWLINE;
                7'h09, 7'h20: k = CLS_SPACE;
                default:
                begin
                    if (cp[6:0] >= "0" && cp[6:0] <= "9")
                        k = CLS_DIGIT;
                    else if ((cp[6:0] >= "A" && cp[6:0] <= "Z") ||
                             (cp[6:0] >= "a" && cp[6:0] <= "z"))
                        k = CLS_LETTER;
                end
            endcase
        end
        return k;
    endfunction

    function automatic void clear_text();
        bytes_left = 2'd0;
        gathered   = '0;
        open_class = CLS_NONE;
        digit_run  = 4'd0;
    endfunction

    // Advance the decoder by one byte; queue a code point when one completes.
    function automatic void take_byte(input logic [7:0] b, input logic eot);
        logic [CP_W-1:0] cp;
        piece_class_t    k;
        logic            joins;
        logic            done;
        decoded_t        due;
        done = 1'b1;
        if (bytes_left != 2'd0)
        begin
            gathered   = {gathered[CP_W-7:0], b[5:0]};
            bytes_left = bytes_left - 2'd1;
            done       = (bytes_left == 2'd0) || eot;
            cp         = gathered;
        end
        else if (!b[7])
            cp = {13'd0, b};
        else if (b[7:5] == 3'b110)
        begin
            gathered   = {16'd0, b[4:0]};
            bytes_left = 2'd1;
            done       = eot;
            cp         = gathered;
        end
        else if (b[7:4] == 4'b1110)
        begin
            gathered   = {17'd0, b[3:0]};
            bytes_left = 2'd2;
            done       = eot;
            cp         = gathered;
        end
        else if (b[7:3] == 5'b11110)
        begin
            gathered   = {18'd0, b[2:0]};
            bytes_left = 2'd3;
            done       = eot;
            cp         = gathered;
        end
        else
            cp = REPLACEMENT_CP;

        if (done)
        begin
            bytes_left = 2'd0;
            gathered   = '0;
            k = lone_class(cp);
            if (k == CLS_DIGIT)
                joins = (open_class == CLS_DIGIT) && (digit_run < run_limit);
            else if (open_class == CLS_OTHER)
                joins = (k == CLS_OTHER) || (k == CLS_LETTER && cp > ASCII_HI);
            else
                joins = (open_class == k);
            if (!joins)
            begin
                open_class = k;
                digit_run  = 4'd0;
            end
            if (k == CLS_DIGIT)
                digit_run = digit_run + 4'd1;
            due = '{point: cp, fresh: !joins, cls: open_class, last: eot};
            points_due.insert(points_due.size(), due);
            if (eot)
                clear_text();
        end
    endfunction

    always @(posedge clk)
    begin
        decoded_t e;
        if (!rst_n)
        begin
            run_limit = MAX_DIGIT_RUN_RESET;
            clear_text();
            points_due.delete();
            fail_count = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (points_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected item: code point %h user %h last %b",
                                 m_tdata, m_tuser, m_tlast);
                end
                else
                begin
                    e = points_due.pop_front();
                    if (m_tdata !== {3'b000, e.point} || m_tuser !== {e.cls, e.fresh} ||
                        m_tlast !== e.last)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: code point exp %h got %h, new piece exp %b got %b,",
                                     e.point, m_tdata, e.fresh, m_tuser[0],
                                     " class exp %0d got %0d, last exp %b got %b",
                                     e.cls, m_tuser[3:1], e.last, m_tlast);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                run_limit = cfg_data;
            if (s_tvalid && s_tready)
                take_byte(s_tdata, s_tlast);
        end
        pending_count = points_due.size();
    end

endmodule

// ===== tb/utf8_pretokenizer_boundary_core_test.sv =====
// Top of the UTF-8 pretokenizer test: clock, reset, byte stimulus and the verdict.
`timescale 1ns / 1ps

module utf8_pretokenizer_boundary_core_test;
    import utf8pt_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = 8'd0;
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;   // [20:0] code_point, [23:21] zero
    logic [3:0]  m_tuser;   // [0] new_piece, [3:1] piece_class
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_data  = 4'd0;

    int fail_count;
    int pending_count;
    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int sent_bytes    = 0;
    int cycles        = 0;

    // Reset value in force first, then both extremes and zero.
    logic [3:0] limit_plan [9] = '{4'd1, 4'd15, 4'd0, 4'd7, 4'd2, 4'd15, 4'd1, 4'd9, 4'd4};

    // One text: digit run split, every class, other piece taking a non-ASCII letter,
    // invalid leads, the largest four-byte value and a cut-short sequence at the end.
    logic [7:0] opening [25] = '{8'h00, 8'h7F, 8'h31, 8'h32, 8'h33, 8'h34, 8'h61, 8'h20,
                                 8'h09, 8'h0D, 8'h0A, 8'h21, 8'hC3, 8'hA9, 8'hE4, 8'hB8,
                                 8'h80, 8'h80, 8'hFF, 8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'hE3,
                                 8'h81};

    utf8_pretokenizer_boundary_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    utf8_pretokenizer_boundary_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Leave tvalid high after acceptance; the next call decides whether to idle.
    task automatic send_byte(input logic [7:0] b, input logic eot);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eot;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent_bytes++;
        @(negedge clk);
    endtask

    // Hold the sender until every expected item is out and the pipeline is empty.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (pending_count != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_limit(input logic [3:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [7:0] cont_byte(input logic [5:0] bits);
        logic [1:0] top;
        // The decoder ignores the marker bits, so vary them now and then.
        top = ($urandom_range(0, 7) == 0) ? 2'($urandom_range(0, 3)) : 2'b10;
        return {top, bits};
    endfunction

    function automatic logic [CP_W-1:0] pick_point();
        logic [CP_W-1:0] cp;
        case ($urandom_range(0, 19))
            0, 1, 2, 3: cp = 21'h30 + 21'($urandom_range(0, 9));
            4, 5:       cp = ($urandom_range(0, 1) ? 21'h41 : 21'h61) +
                             21'($urandom_range(0, 25));
            6:          cp = $urandom_range(0, 1) ? 21'h20 : 21'h09;
            7:          cp = $urandom_range(0, 1) ? 21'h0D : 21'h0A;
            8, 9:       cp = 21'($urandom_range(0, 'h7F));
            10:         cp = 21'($urandom_range('h4E00, 'h9FFF));
            11:         cp = 21'($urandom_range('h3040, 'h30FF));
            12:         cp = 21'($urandom_range('h3400, 'h4DBF));
            13:         cp = 21'($urandom_range('h80, 'h7FF));
            14:         cp = 21'($urandom_range('h800, 'hFFFF));
            15:         cp = 21'($urandom_range('h10000, 'h1FFFFF));
            16:
            begin
                case ($urandom_range(0, 13))
                    0:  cp = 21'h303F;
                    1:  cp = 21'h3040;
                    2:  cp = 21'h30FF;
                    3:  cp = 21'h3100;
                    4:  cp = 21'h33FF;
                    5:  cp = 21'h3400;
                    6:  cp = 21'h4DBF;
                    7:  cp = 21'h4DC0;
                    8:  cp = 21'h4DFF;
                    9:  cp = 21'h4E00;
                    10: cp = 21'h9FFF;
                    11: cp = 21'hA000;
                    12: cp = 21'h80;
                    default: cp = 21'h1FFFFF;
                endcase
            end
            17:         cp = 21'($urandom_range('h21, 'h2F));
            default:    cp = 21'($urandom_range('hA0, 'h24F));
        endcase
        return cp;
    endfunction

    // Encode one code point; when cut is set, drop its trailing bytes.
    task automatic send_point(input logic [CP_W-1:0] cp, input logic last, input logic cut);
        logic [7:0] seq [4];
        int         n;
        if (cp < 21'h80)
        begin
            seq[0] = cp[7:0];
            n      = 1;
        end
        else if (cp < 21'h800)
        begin
            seq[0] = {3'b110, cp[10:6]};
            seq[1] = cont_byte(cp[5:0]);
            n      = 2;
        end
        else if (cp < 21'h10000)
        begin
            seq[0] = {4'b1110, cp[15:12]};
            seq[1] = cont_byte(cp[11:6]);
            seq[2] = cont_byte(cp[5:0]);
            n      = 3;
        end
        else
        begin
            seq[0] = {5'b11110, cp[20:18]};
            seq[1] = cont_byte(cp[17:12]);
            seq[2] = cont_byte(cp[11:6]);
            seq[3] = cont_byte(cp[5:0]);
            n      = 4;
        end
        if (cut && n > 1)
            n = $urandom_range(1, n - 1);
        for (int i = 0; i < n; i++)
            send_byte(seq[i], last && (i == n - 1));
    endtask

    task automatic send_text();
        int         len;
        logic       last;
        logic [7:0] junk;
        len = $urandom_range(1, 12);
        if ($urandom_range(0, 9) == 0)
        begin
            // Raw noise, any byte at all
            for (int i = 0; i < len; i++)
                send_byte(8'($urandom_range(0, 255)), i == len - 1);
        end
        else
        begin
            for (int i = 0; i < len; i++)
            begin
                last = (i == len - 1);
                if ($urandom_range(0, 19) == 0)
                begin
                    junk = $urandom_range(0, 1) ? 8'($urandom_range('h80, 'hBF)) :
                                                  8'($urandom_range('hF8, 'hFF));
                    send_byte(junk, last);
                end
                else
                    send_point(pick_point(), last, last && ($urandom_range(0, 5) == 0));
            end
        end
    endtask

    initial
    begin
        int target;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        src_idle_pct  = 22;
        sink_idle_pct = 88;
        for (int i = 0; i < 25; i++)
            send_byte(opening[i], i == 24);
        // Text made of one lone lead byte
        send_byte(8'hC2, 1'b1);

        limit_plan[7] = 4'($urandom_range(0, 15));
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    src_idle_pct  = 22;
                    sink_idle_pct = 88;
                end
                1:
                begin
                    src_idle_pct  = 88;
                    sink_idle_pct = 22;
                end
                default:
                begin
                    src_idle_pct  = 0;
                    sink_idle_pct = 0;
                end
            endcase
            for (int blk = 0; blk < 3; blk++)
            begin
                drain();
                write_limit(limit_plan[phase * 3 + blk]);
                target = sent_bytes + 200;
                while (sent_bytes < target)
                    send_text();
            end
        end

        drain();
        repeat (20) @(negedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
